@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the keyframe vertex block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under the block clock and reset.
`define KVDL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kvdl assertion failed");

// Next-cycle implication under the block clock and reset.
`define KVDL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kvdl assertion failed");

`endif

@@ rtl/core/kvdl_pkg.sv @@
// Package with shared constants and helpers of the keyframe vertex block.
`timescale 1ns / 1ps
package kvdl_pkg;
	localparam int WEIGHT_BITS = 16;
	localparam int MSCALE_BITS = 16;
	localparam logic [16:0] WEIGHT_ONE = 17'd65536;
	localparam int SKIN_W = 13;

	typedef enum logic [1:0] {
		CFG_INTERP = 2'd0,
		CFG_MSCALE = 2'd1,
		CFG_SKIN_W = 2'd2,
		CFG_SKIN_H = 2'd3
	} cfg_index_t;

	typedef enum logic {
		REQ_VERTEX = 1'b0,
		REQ_LOAD = 1'b1
	} req_type_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] x);
		logic [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (x < -64'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction
endpackage

@@ rtl/core/keyframe_vertex_decompress_lerp.sv @@
// Top level of the keyframe vertex decompressor with frame interpolation.
// The texture divider, one quotient bit per stage, sets depth; it yields Q16.16 at FRAC_BITS 16.
// Throughput is one item per cycle while out_stall is low.
// Every stage moves on its own, so a bubble is filled while a result waits at the output.
// Reset clears the valid bits and the transform store and sets the config defaults at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module keyframe_vertex_decompress_lerp #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic req_type,
	input logic [2:0] transform_index,
	input logic signed [31:0] scale_q,
	input logic signed [31:0] translate_q,
	input logic [23:0] vertex_a,
	input logic [23:0] vertex_b,
	input logic signed [15:0] tex_s,
	input logic signed [15:0] tex_t,
	input logic last_in_mesh,
	output logic out_valid,
	input logic out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [31:0] tex_u,
	output logic signed [31:0] tex_v,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [23:0] cfg_data
);
	localparam int L = 16 + FRAC_BITS + 3;
	localparam int SW = kvdl_pkg::SKIN_W;

	logic [L:1] valid_s;
	logic [L+1:1] ready;
	logic req_s1;
	logic [2:0] idx_s1;
	logic [31:0] scale_s1;
	logic [31:0] trans_s1;
	logic [23:0] va_s1;
	logic [23:0] vb_s1;
	logic signed [15:0] ts_s1;
	logic signed [15:0] tt_s1;
	logic last_s [1:L];
	logic [31:0] scale_store_q [6];
	logic [31:0] offset_store_q [6];
	logic [16:0] interp_weight_q;
	logic [23:0] model_scale_q;
	logic [SW-1:0] skin_width_q;
	logic [SW-1:0] skin_height_q;
	logic store_we;
	logic [16:0] w_in;
	logic [SW-1:0] skin_in;

	always_comb begin
		ready[L+1] = !out_stall;
		for (int k = L; k >= 1; k--) begin
			ready[k] = !valid_s[k] || ready[k+1];
		end
	end

	assign in_stall = !ready[1];
	assign out_valid = valid_s[L];
	assign cfg_ready = 1'b1;
	assign store_we = ready[2] && valid_s[1] && (req_s1 == kvdl_pkg::REQ_LOAD) && (idx_s1 < 3'd6);
	assign w_in = cfg_data[16:0];
	assign skin_in = (cfg_data[SW-1:0] == '0) ? SW'(1) : cfg_data[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (ready[1]) begin
				valid_s[1] <= in_valid;
			end
			if (ready[2]) begin
				valid_s[2] <= valid_s[1] && (req_s1 == kvdl_pkg::REQ_VERTEX);
			end
			for (int k = 3; k <= L; k++) begin
				if (ready[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready[1]) begin
			req_s1 <= req_type;
			idx_s1 <= transform_index;
			scale_s1 <= scale_q;
			trans_s1 <= translate_q;
			va_s1 <= vertex_a;
			vb_s1 <= vertex_b;
			ts_s1 <= tex_s;
			tt_s1 <= tex_t;
			last_s[1] <= last_in_mesh;
		end
		for (int k = 2; k <= L; k++) begin
			if (ready[k]) begin
				last_s[k] <= last_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				scale_store_q[i] <= '0;
				offset_store_q[i] <= '0;
			end
		end else if (store_we) begin
			scale_store_q[idx_s1] <= scale_s1;
			offset_store_q[idx_s1] <= trans_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_weight_q <= '0;
			model_scale_q <= 24'd65536;
			skin_width_q <= SW'(256);
			skin_height_q <= SW'(256);
		end else if (cfg_valid) begin
			unique case (kvdl_pkg::cfg_index_t'(cfg_index))
				kvdl_pkg::CFG_INTERP: begin
					interp_weight_q <= (w_in > kvdl_pkg::WEIGHT_ONE) ? kvdl_pkg::WEIGHT_ONE : w_in;
				end
				kvdl_pkg::CFG_MSCALE: begin
					model_scale_q <= cfg_data;
				end
				kvdl_pkg::CFG_SKIN_W: begin
					skin_width_q <= skin_in;
				end
				kvdl_pkg::CFG_SKIN_H: begin
					skin_height_q <= skin_in;
				end
				default: begin
				end
			endcase
		end
	end

	kvdl_pos #(
		.DEPTH(L)
	) u_pos (
		.clk(clk),
		.en(ready[L:1]),
		.va(va_s1),
		.vb(vb_s1),
		.scale(scale_store_q),
		.offset(offset_store_q),
		.weight(interp_weight_q),
		.mscale(model_scale_q),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z)
	);

	kvdl_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div_u (
		.clk(clk),
		.en(ready[L:1]),
		.coord(ts_s1),
		.divisor(skin_width_q),
		.quo(tex_u)
	);

	kvdl_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div_v (
		.clk(clk),
		.en(ready[L:1]),
		.coord(tt_s1),
		.divisor(skin_height_q),
		.quo(tex_v)
	);

	assign last = last_s[L];

	`KVDL_ASSERT_NOW(a_bubble_takes_input, !valid_s[1], !in_stall)
	`KVDL_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(tex_u))
	`KVDL_ASSERT_NEXT(a_vertex_enters, in_valid && !in_stall && (req_type == kvdl_pkg::REQ_VERTEX),
		valid_s[1] && (req_s1 == kvdl_pkg::REQ_VERTEX))
endmodule

@@ rtl/core/kvdl_pos.sv @@
// Position pipeline: frame transform, lerp, model scale and saturation.
`timescale 1ns / 1ps
module kvdl_pos #(
	parameter int DEPTH = 8
) (
	input logic clk,
	input logic [DEPTH:1] en,
	input logic [23:0] va,
	input logic [23:0] vb,
	input logic [31:0] scale [6],
	input logic [31:0] offset [6],
	input logic [16:0] weight,
	input logic [23:0] mscale,
	output logic [31:0] pos_x,
	output logic [31:0] pos_y,
	output logic [31:0] pos_z
);
	logic signed [40:0] a_s2 [3];
	logic signed [40:0] b_s2 [3];
	logic signed [40:0] a_s3 [3];
	logic signed [41:0] d_s3 [3];
	logic signed [40:0] a_s4 [3];
	logic signed [58:0] dw_s4 [3];
	logic signed [43:0] p_s5 [3];
	logic signed [67:0] pm_s6 [3];
	logic [31:0] dly [7:DEPTH][3];

	function automatic logic signed [40:0] axis_mul(input logic [31:0] s, input logic [7:0] v,
			input logic [31:0] t);
		logic signed [40:0] sx;
		logic signed [40:0] vx;
		logic signed [40:0] tx;
		sx = 41'($signed(s));
		vx = $signed({33'd0, v});
		tx = 41'($signed(t));
		return sx * vx + tx;
	endfunction

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (en[2]) begin
				a_s2[k] <= axis_mul(scale[k], va[8*k +: 8], offset[k]);
				b_s2[k] <= axis_mul(scale[3+k], vb[8*k +: 8], offset[3+k]);
			end
			if (en[3]) begin
				a_s3[k] <= a_s2[k];
				d_s3[k] <= 42'(b_s2[k]) - 42'(a_s2[k]);
			end
			if (en[4]) begin
				a_s4[k] <= a_s3[k];
				dw_s4[k] <= 59'(d_s3[k]) * $signed({42'd0, weight});
			end
			if (en[5]) begin
				p_s5[k] <= 44'(a_s4[k]) + 44'(dw_s4[k] >>> kvdl_pkg::WEIGHT_BITS);
			end
			if (en[6]) begin
				pm_s6[k] <= 68'(p_s5[k]) * $signed({44'd0, mscale});
			end
			if (en[7]) begin
				dly[7][k] <= kvdl_pkg::sat32(64'(pm_s6[k] >>> kvdl_pkg::MSCALE_BITS));
			end
		end
	end

	for (genvar s = 8; s <= DEPTH; s++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en[s]) begin
				dly[s] <= dly[s-1];
			end
		end
	end

	assign pos_x = dly[DEPTH][0];
	assign pos_y = dly[DEPTH][2];
	assign pos_z = dly[DEPTH][1];
endmodule

@@ rtl/core/kvdl_div.sv @@
// Pipelined restoring divider for one texture coordinate, one quotient bit a stage.
`timescale 1ns / 1ps
module kvdl_div #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic [16+FRAC_BITS+3:1] en,
	input logic signed [15:0] coord,
	input logic [kvdl_pkg::SKIN_W-1:0] divisor,
	output logic [31:0] quo
);
	localparam int QW = 16 + FRAC_BITS;
	localparam int LAST = QW + 3;
	localparam int RW = kvdl_pkg::SKIN_W;

	logic [RW-1:0] rem_s [2:QW+2];
	logic [QW-1:0] n_s [2:QW+2];
	logic [QW-1:0] q_s [2:QW+2];
	logic neg_s [2:QW+2];
	logic [31:0] res_s;

	function automatic logic signed [QW:0] apply_sign(input logic neg, input logic [QW-1:0] q);
		logic signed [QW:0] v;
		v = $signed({1'b0, q});
		return neg ? -v : v;
	endfunction

	always_ff @(posedge clk) begin
		if (en[2]) begin
			neg_s[2] <= coord[15];
			n_s[2] <= QW'(coord[15] ? 16'(-coord) : 16'(coord)) << FRAC_BITS;
			rem_s[2] <= '0;
			q_s[2] <= '0;
		end
		if (en[LAST]) begin
			res_s <= kvdl_pkg::sat32(64'(apply_sign(neg_s[QW+2], q_s[QW+2])));
		end
	end

	for (genvar i = 3; i <= QW + 2; i++) begin : g_bit
		logic [RW:0] t;
		logic ge;
		assign t = {rem_s[i-1], n_s[i-1][QW-1]};
		assign ge = t >= {1'b0, divisor};
		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_s[i] <= ge ? RW'(t - {1'b0, divisor}) : RW'(t);
				n_s[i] <= n_s[i-1] << 1;
				q_s[i] <= {q_s[i-1][QW-2:0], ge};
				neg_s[i] <= neg_s[i-1];
			end
		end
	end

	assign quo = res_s;
endmodule

@@ test/keyframe_vertex_decompress_lerp_test.sv @@
// Self-checking testbench for the keyframe vertex decompressor with frame interpolation.
`timescale 1ns / 1ps
module keyframe_vertex_decompress_lerp_test;
	typedef struct packed {
		logic req;
		logic [2:0] idx;
		logic [31:0] scale;
		logic [31:0] offset;
		logic [23:0] va;
		logic [23:0] vb;
		logic [15:0] ts;
		logic [15:0] tt;
		logic lst;
	} beat_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] u;
		logic [31:0] v;
		logic lst;
	} vertex_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic [2:0] transform_index = '0;
	logic signed [31:0] scale_q = '0;
	logic signed [31:0] translate_q = '0;
	logic [23:0] vertex_a = '0;
	logic [23:0] vertex_b = '0;
	logic signed [15:0] tex_s = '0;
	logic signed [15:0] tex_t = '0;
	logic last_in_mesh = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] pos_x, pos_y, pos_z, tex_u, tex_v;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	keyframe_vertex_decompress_lerp uut (.*);

	always #10 clk = ~clk;

	// Predictor state.
	logic [16:0] weight_reg;
	logic [23:0] mscale_reg;
	logic [12:0] skin_w_reg, skin_h_reg;
	logic signed [31:0] frame_scale [6];
	logic signed [31:0] frame_offset [6];

	beat_t pending_beats[$];
	vertex_out_t expected_vertices[$];
	int failures = 0;
	int accepted = 0;
	int queued = 0;

	function automatic logic signed [63:0] floor16(input logic signed [63:0] x);
		return x >>> 16;
	endfunction

	function automatic logic [31:0] clamp32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) return 32'h7fff_ffff;
		if (x < -64'sd2147483648) return 32'h8000_0000;
		return x[31:0];
	endfunction

	function automatic logic [31:0] blend_axis(input int ax, input logic [23:0] va,
			input logic [23:0] vb);
		logic signed [63:0] a, b, p, hi, lo, m, r;
		a = 64'(frame_scale[ax]) * $signed({56'd0, va[8*ax +: 8]}) + 64'(frame_offset[ax]);
		b = 64'(frame_scale[3+ax]) * $signed({56'd0, vb[8*ax +: 8]})
			+ 64'(frame_offset[3+ax]);
		p = a + floor16((b - a) * $signed({47'd0, weight_reg}));
		hi = floor16(p);
		lo = p - (hi <<< 16);
		m = $signed({40'd0, mscale_reg});
		r = hi * m + $signed(64'((64'(lo) * 64'(m)) >> 16));
		return clamp32(r);
	endfunction

	function automatic logic [31:0] tex_scale(input logic [15:0] c, input logic [12:0] d);
		logic signed [63:0] n, q;
		n = 64'($signed(c)) * 64'sd65536;
		q = n / $signed({51'd0, (d == 0) ? 13'd1 : d});
		return clamp32(q);
	endfunction

	task automatic predict_beat(input beat_t it);
		vertex_out_t e;
		if (it.req == kvdl_pkg::REQ_LOAD) begin
			if (it.idx < 6) begin
				frame_scale[it.idx] = it.scale;
				frame_offset[it.idx] = it.offset;
			end
		end else begin
			e.x = blend_axis(0, it.va, it.vb);
			e.y = blend_axis(2, it.va, it.vb);
			e.z = blend_axis(1, it.va, it.vb);
			e.u = tex_scale(it.ts, skin_w_reg);
			e.v = tex_scale(it.tt, skin_h_reg);
			e.lst = it.lst;
			expected_vertices.push_back(e);
		end
	endtask

	// Driver.
	int in_gap = 0;
	int out_gap = 0;
	logic in_taken = 1'b0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap--;
				end else if (pending_beats.size() > 0) begin
					beat_t it;
					it = pending_beats.pop_front();
					req_type <= it.req;
					transform_index <= it.idx;
					scale_q <= it.scale;
					translate_q <= it.offset;
					vertex_a <= it.va;
					vertex_b <= it.vb;
					tex_s <= it.ts;
					tex_t <= it.tt;
					last_in_mesh <= it.lst;
					in_valid <= 1'b1;
					in_gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 12));
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (out_gap > 0) begin
				out_stall <= 1'b1;
				out_gap--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Input monitor feeds the predictor.
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			predict_beat('{req_type, transform_index, scale_q, translate_q, vertex_a,
				vertex_b, tex_s, tex_t, last_in_mesh});
			accepted++;
		end
	end

	// Output monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			out_gap = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 12)) : 0;
			if (expected_vertices.size() == 0) begin
				$display("%0t: unexpected beat x=%h", $time, pos_x);
				failures++;
			end else begin
				vertex_out_t e;
				e = expected_vertices.pop_front();
				if (pos_x !== e.x) begin
					$display("%0t: pos_x expected %h actual %h", $time, e.x, pos_x);
					failures++;
				end
				if (pos_y !== e.y) begin
					$display("%0t: pos_y expected %h actual %h", $time, e.y, pos_y);
					failures++;
				end
				if (pos_z !== e.z) begin
					$display("%0t: pos_z expected %h actual %h", $time, e.z, pos_z);
					failures++;
				end
				if (tex_u !== e.u) begin
					$display("%0t: tex_u expected %h actual %h", $time, e.u, tex_u);
					failures++;
				end
				if (tex_v !== e.v) begin
					$display("%0t: tex_v expected %h actual %h", $time, e.v, tex_v);
					failures++;
				end
				if (last !== e.lst) begin
					$display("%0t: last expected %b actual %b", $time, e.lst, last);
					failures++;
				end
			end
		end
	end

	function automatic beat_t load_beat(input logic [2:0] idx, input logic [31:0] s,
			input logic [31:0] o);
		beat_t it;
		it = '{default: '0};
		it.req = kvdl_pkg::REQ_LOAD;
		it.idx = idx;
		it.scale = s;
		it.offset = o;
		it.va = 24'($urandom);
		it.ts = 16'($urandom);
		return it;
	endfunction

	function automatic beat_t vertex_beat(input logic [23:0] va, input logic [23:0] vb,
			input logic [15:0] ts, input logic [15:0] tt);
		beat_t it;
		it.req = kvdl_pkg::REQ_VERTEX;
		it.idx = 3'($urandom);
		it.scale = $urandom;
		it.offset = $urandom;
		it.va = va;
		it.vb = vb;
		it.ts = ts;
		it.tt = tt;
		it.lst = 1'($urandom);
		return it;
	endfunction

	function automatic logic [31:0] rand_q();
		unique case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 65536 * 4) - 65536 * 2;
			default: return $urandom;
		endcase
	endfunction

	task automatic push(input beat_t it);
		pending_beats.push_back(it);
		queued++;
	endtask

	task automatic wait_drained();
		while (accepted < queued || expected_vertices.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input kvdl_pkg::cfg_index_t idx, input logic [23:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		unique case (idx)
			kvdl_pkg::CFG_INTERP: weight_reg = (val[16:0] > kvdl_pkg::WEIGHT_ONE) ?
				kvdl_pkg::WEIGHT_ONE : val[16:0];
			kvdl_pkg::CFG_MSCALE: mscale_reg = val;
			kvdl_pkg::CFG_SKIN_W: skin_w_reg = val[12:0];
			default: skin_h_reg = val[12:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 5) == 0)
				push(load_beat(3'($urandom_range(0, 7)), rand_q(), rand_q()));
			else
				push(vertex_beat(24'($urandom), 24'($urandom), 16'($urandom),
					16'($urandom)));
		end
	endtask

	initial begin
		weight_reg = '0;
		mscale_reg = 24'd65536;
		skin_w_reg = 13'd256;
		skin_h_reg = 13'd256;
		for (int i = 0; i < 6; i++) begin
			frame_scale[i] = '0;
			frame_offset[i] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: zero store, full loads, extremes of fields, ignored indexes.
		push(vertex_beat(24'hffffff, 24'h000000, 16'h7fff, 16'h8000));
		for (int i = 0; i < 6; i++) push(load_beat(3'(i), 32'h0001_0000 * (i + 1), 32'h8000 * i));
		push(load_beat(3'd6, 32'h7fff_ffff, 32'h7fff_ffff));
		push(load_beat(3'd7, 32'h8000_0000, 32'h8000_0000));
		push(vertex_beat(24'h000000, 24'hffffff, 16'h0000, 16'hffff));
		push(vertex_beat(24'hffffff, 24'hffffff, 16'h8000, 16'h7fff));
		push(vertex_beat(24'h123456, 24'h654321, 16'h0001, 16'hffff));
		push(load_beat(3'd0, 32'h7fff_ffff, 32'h7fff_ffff));
		push(load_beat(3'd5, 32'h8000_0000, 32'h8000_0000));
		push(vertex_beat(24'hffffff, 24'hffffff, 16'h1234, 16'h4321));
		wait_drained();

		write_reg(kvdl_pkg::CFG_INTERP, 24'd65536);
		write_reg(kvdl_pkg::CFG_MSCALE, 24'hffffff);
		write_reg(kvdl_pkg::CFG_SKIN_W, 24'd1);
		write_reg(kvdl_pkg::CFG_SKIN_H, 24'd4096);
		push(vertex_beat(24'hffffff, 24'h000000, 16'h7fff, 16'h8000));
		push(vertex_beat(24'h000000, 24'hffffff, 16'h8000, 16'h7fff));
		random_phase(120);
		wait_drained();

		write_reg(kvdl_pkg::CFG_INTERP, 24'h01ffff);
		write_reg(kvdl_pkg::CFG_MSCALE, 24'd0);
		write_reg(kvdl_pkg::CFG_SKIN_W, 24'd0);
		write_reg(kvdl_pkg::CFG_SKIN_H, 24'h1fff);
		random_phase(120);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(kvdl_pkg::CFG_INTERP, 24'($urandom_range(0, 65536)));
			write_reg(kvdl_pkg::CFG_MSCALE, ($urandom_range(0, 2) == 0) ?
				24'($urandom) : 24'($urandom_range(0, 131072)));
			write_reg(kvdl_pkg::CFG_SKIN_W, 24'($urandom_range(1, 4096)));
			write_reg(kvdl_pkg::CFG_SKIN_H, 24'($urandom_range(1, 4096)));
			random_phase(125);
			wait_drained();
		end

		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
